/* design/orbm_pkg.sv */
// ---------------------------------------------------------------------------
// orbm_pkg: shared types and constants of the oriented rod box mesher
// Holds the transaction structs, the fixed-point vector types and the rod
// record handed from the axis pipeline to the vertex emitter.
// ---------------------------------------------------------------------------
package orbm_pkg;

  // Latency of one normalize unit in register stages.
  localparam int NORM_LAT = 74;

  // Index of the final vertex of one rod.
  localparam logic [5:0] VERT_LAST = 6'd35;

  typedef logic signed [32:0] cval_t;   // cross product component
  typedef cval_t [2:0]        cvec_t;
  typedef logic signed [31:0] uval_t;   // Q2.30 unit component, Q16.16 position
  typedef uval_t [2:0]        uvec_t;
  typedef logic signed [33:0] mval_t;   // main half-axis component, Q16.16 wide
  typedef mval_t [2:0]        mvec_t;
  typedef logic signed [15:0] nval_t;   // Q1.14 normal or direction component
  typedef nval_t [2:0]        nvec_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        rod_length;
    logic [30:0]        rod_diameter;
    logic [9:0]         rod_slot;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         slot_out;
    logic [5:0]         vertex_number;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               degenerate;
    logic               last_vertex;
  } out_item_t;

  // Everything the emitter needs to produce the 36 vertices of one rod.
  typedef struct packed {
    logic [9:0]   slot;
    logic         degen;
    uvec_t        cen;
    mvec_t        m;
    uvec_t        f;
    uvec_t        s;
    nvec_t [2:0]  nrm;   // per axis: main, first, second
  } rod_t;

endpackage

/* design/oriented_rod_box_mesher.sv */
// ---------------------------------------------------------------------------
// oriented_rod_box_mesher: rod to 36-vertex box mesh
// The first vertex of a rod reaches the outputs after T0, T1, the normalize
// units, T3, T4 and the emitter; its 36 vertices follow, one per cycle.
// The single vertex emitter works on one rod at a time.
// Reset (rst_n low, synchronous) drops every rod in flight and clears all
// valid bits. The result receiver cannot stall.
// ---------------------------------------------------------------------------
module oriented_rod_box_mesher #(
  parameter int ROD_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  orbm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output orbm_pkg::out_item_t out_item
);

  // The front end is one long pipeline that moves as a whole: it advances
  // whenever its last stage is empty or the emitter takes that stage's rod.
  // Stages:
  //   T0  input register
  //   T1  cross products that define the two side directions
  //   N   three normalize units (74 stages) beside a delay line for the rest
  //   T3  axis products (dir times length plus diameter, unit times diameter)
  //   T4  round-to-nearest of the axes and normals, rod record ready
  // The emitter then walks the 36 corner vertices of the box. A transaction
  // whose slot is out of range is accepted but carries no valid bit, so it
  // gives no vertices.

  typedef struct packed {
    orbm_pkg::uvec_t cen;
    orbm_pkg::nvec_t dir;
    logic [31:0]     sumld;
    logic [30:0]     dia;
    logic [9:0]      slot;
  } side_t;

  localparam int NL = orbm_pkg::NORM_LAT;

  logic               adv;
  logic               in_accept;
  logic               slot_ok;
  logic               emit_free;
  logic               emit_load;

  logic               t0_v_r;
  orbm_pkg::in_item_t t0_r;

  logic               t1_v_r;
  orbm_pkg::cvec_t    t1_dv_r, t1_c1_r, t1_c2_r;
  orbm_pkg::cvec_t    t1_dv_nxt, t1_c1_nxt, t1_c2_nxt;
  side_t              t1_side_r, t1_side_nxt;

  logic [NL-1:0]      dl_v_r;
  side_t              dl_r [NL];

  orbm_pkg::uvec_t    um, uf, us;
  logic               zero_m;

  logic               t3_v_r;
  logic signed [2:0][48:0] t3_pm_r;
  logic signed [2:0][63:0] t3_pf_r, t3_ps_r;
  orbm_pkg::uvec_t    t3_um_r, t3_uf_r, t3_us_r;
  logic               t3_degen_r;
  orbm_pkg::uvec_t    t3_cen_r;
  logic [9:0]         t3_slot_r;

  logic               t4_v_r;
  orbm_pkg::rod_t     t4_rod_r, t4_rod_nxt;

  // Round-to-nearest, ties away from zero, for the three scalings in use.
  function automatic orbm_pkg::mval_t rnd_m(input logic signed [48:0] p);
    logic [48:0] mag;
    logic [48:0] r;
    mag = p[48] ? 49'(-p) : 49'(p);
    r   = (mag + 49'd16384) >> 15;
    return p[48] ? -$signed(r[33:0]) : $signed(r[33:0]);
  endfunction

  function automatic orbm_pkg::uval_t rnd_a(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + 64'd1073741824) >> 31;
    return p[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic orbm_pkg::nval_t rnd_n(input logic signed [31:0] u);
    logic [31:0] mag;
    logic [31:0] r;
    mag = u[31] ? 32'(-u) : 32'(u);
    r   = (mag + 32'd32768) >> 16;
    return u[31] ? -$signed(r[15:0]) : $signed(r[15:0]);
  endfunction

  assign slot_ok   = 32'(in_item.rod_slot) < ROD_SLOTS;
  assign emit_load = t4_v_r && emit_free;
  assign adv       = !t4_v_r || emit_free;
  assign busy      = !adv;
  assign in_accept = start && !busy;

  // T1: the first side direction is dir x z, or dir x x when that vanishes;
  // the second is dir x first, written out for both cases.
  always_comb begin
    orbm_pkg::cval_t dx, dy, dz;
    dx = orbm_pkg::cval_t'(t0_r.dir_x);
    dy = orbm_pkg::cval_t'(t0_r.dir_y);
    dz = orbm_pkg::cval_t'(t0_r.dir_z);
    t1_dv_nxt[0] = dx;
    t1_dv_nxt[1] = dy;
    t1_dv_nxt[2] = dz;
    if (t0_r.dir_x != '0 || t0_r.dir_y != '0) begin
      t1_c1_nxt[0] = dy;
      t1_c1_nxt[1] = -dx;
      t1_c1_nxt[2] = '0;
      t1_c2_nxt[0] = dz * dx;
      t1_c2_nxt[1] = dz * dy;
      t1_c2_nxt[2] = -(dx * dx + dy * dy);
    end else begin
      t1_c1_nxt[0] = '0;
      t1_c1_nxt[1] = dz;
      t1_c1_nxt[2] = '0;
      t1_c2_nxt[0] = -(dz * dz);
      t1_c2_nxt[1] = '0;
      t1_c2_nxt[2] = '0;
    end
    t1_side_nxt.cen[0] = t0_r.center_x;
    t1_side_nxt.cen[1] = t0_r.center_y;
    t1_side_nxt.cen[2] = t0_r.center_z;
    t1_side_nxt.dir[0] = t0_r.dir_x;
    t1_side_nxt.dir[1] = t0_r.dir_y;
    t1_side_nxt.dir[2] = t0_r.dir_z;
    t1_side_nxt.sumld  = 32'(t0_r.rod_length) + 32'(t0_r.rod_diameter);
    t1_side_nxt.dia    = t0_r.rod_diameter;
    t1_side_nxt.slot   = t0_r.rod_slot;
  end

  orbm_norm u_norm_main (
    .clk    (clk),
    .en     (adv),
    .c_i    (t1_dv_r),
    .u_o    (um),
    .zero_o (zero_m)
  );

  orbm_norm u_norm_first (
    .clk    (clk),
    .en     (adv),
    .c_i    (t1_c1_r),
    .u_o    (uf),
    .zero_o ()
  );

  orbm_norm u_norm_second (
    .clk    (clk),
    .en     (adv),
    .c_i    (t1_c2_r),
    .u_o    (us),
    .zero_o ()
  );

  // T4: rounded axes and normals. A zero direction or a zero diameter
  // makes the rod degenerate, and then every normal is zero.
  always_comb begin
    t4_rod_nxt.slot  = t3_slot_r;
    t4_rod_nxt.degen = t3_degen_r;
    t4_rod_nxt.cen   = t3_cen_r;
    for (int i = 0; i < 3; i++) begin
      t4_rod_nxt.m[i]      = rnd_m(t3_pm_r[i]);
      t4_rod_nxt.f[i]      = rnd_a(t3_pf_r[i]);
      t4_rod_nxt.s[i]      = rnd_a(t3_ps_r[i]);
      t4_rod_nxt.nrm[0][i] = t3_degen_r ? '0 : rnd_n(t3_um_r[i]);
      t4_rod_nxt.nrm[1][i] = t3_degen_r ? '0 : rnd_n(t3_uf_r[i]);
      t4_rod_nxt.nrm[2][i] = t3_degen_r ? '0 : rnd_n(t3_us_r[i]);
    end
  end

  // Valid bits of the front end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
      t1_v_r <= 1'b0;
      dl_v_r <= '0;
      t3_v_r <= 1'b0;
      t4_v_r <= 1'b0;
    end else if (adv) begin
      t0_v_r <= in_accept && slot_ok;
      t1_v_r <= t0_v_r;
      dl_v_r <= {dl_v_r[NL-2:0], t1_v_r};
      t3_v_r <= dl_v_r[NL-1];
      t4_v_r <= t3_v_r;
    end
  end

  // Payload of the front end.
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r      <= in_item;
      t1_dv_r   <= t1_dv_nxt;
      t1_c1_r   <= t1_c1_nxt;
      t1_c2_r   <= t1_c2_nxt;
      t1_side_r <= t1_side_nxt;
      dl_r[0]   <= t1_side_r;
      for (int k = 1; k < NL; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        t3_pm_r[i] <= $signed(dl_r[NL-1].dir[i]) * $signed({1'b0, dl_r[NL-1].sumld});
        t3_pf_r[i] <= $signed(uf[i]) * $signed({1'b0, dl_r[NL-1].dia});
        t3_ps_r[i] <= $signed(us[i]) * $signed({1'b0, dl_r[NL-1].dia});
      end
      t3_um_r    <= um;
      t3_uf_r    <= uf;
      t3_us_r    <= us;
      t3_degen_r <= zero_m || (dl_r[NL-1].dia == '0);
      t3_cen_r   <= dl_r[NL-1].cen;
      t3_slot_r  <= dl_r[NL-1].slot;
      t4_rod_r   <= t4_rod_nxt;
    end
  end

  orbm_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (emit_load),
    .rod_i       (t4_rod_r),
    .free_o      (emit_free),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule

/* design/orbm_norm.sv */
// ---------------------------------------------------------------------------
// orbm_norm: pipelined vector normalize
// Turns a vector into a Q2.30 unit vector through a pre-scale, a one bit per
// stage square root and a one bit per stage divide, 74 stages in all.
// ---------------------------------------------------------------------------
module orbm_norm (
  input  logic            clk,
  input  logic            en,
  input  orbm_pkg::cvec_t c_i,
  output orbm_pkg::uvec_t u_o,
  output logic            zero_o
);

  localparam int PS_STEPS = 5;
  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 31;

  typedef struct packed {
    logic [63:0]      s;
    logic [4:0]       h;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } ps_t;

  typedef struct packed {
    logic [63:0]      n;
    logic [63:0]      res;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] x;
  } sq_t;

  typedef struct packed {
    logic [2:0][32:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] quo;
    logic [31:0]      q;
    logic             zero;
    logic [2:0]       neg;
  } dv_t;

  logic [2:0][31:0] mag_a_r, mag_a_nxt, mag_b_r;
  logic [2:0]       neg_a_r, neg_a_nxt, neg_b_r;
  logic [2:0][63:0] sq_b_r;
  ps_t              ps_r  [PS_STEPS+1];
  ps_t              ps_nxt[PS_STEPS+1];
  sq_t              sq_r  [SQ_STEPS+1];
  sq_t              sq_nxt[SQ_STEPS+1];
  dv_t              dv_r  [DV_STEPS+1];
  dv_t              dv_nxt[DV_STEPS+1];
  orbm_pkg::uvec_t  u_r, u_nxt;
  logic             zero_r;

  // Magnitude and sign of each component.
  always_comb begin
    orbm_pkg::cval_t abs_c;
    for (int i = 0; i < 3; i++) begin
      neg_a_nxt[i] = c_i[i][32];
      abs_c        = c_i[i][32] ? -c_i[i] : c_i[i];
      mag_a_nxt[i] = abs_c[31:0];
    end
  end

  // Sum of squares, then a pre-scale by powers of four until it reaches 2^60.
  always_comb begin
    int          sh;
    logic [63:0] lim;
    ps_nxt[0].s    = sq_b_r[0] + sq_b_r[1] + sq_b_r[2];
    ps_nxt[0].h    = '0;
    ps_nxt[0].zero = (mag_b_r == '0);
    ps_nxt[0].neg  = neg_b_r;
    ps_nxt[0].mag  = mag_b_r;
    for (int j = 0; j < PS_STEPS; j++) begin
      sh  = 32 >> j;
      lim = 64'd1 << (62 - sh);
      ps_nxt[j+1] = ps_r[j];
      if (ps_r[j].s < lim) begin
        ps_nxt[j+1].s = ps_r[j].s << sh;
        ps_nxt[j+1].h = ps_r[j].h + 5'(sh / 2);
      end
    end
  end

  // Scaled components and the square root, one result bit per stage.
  always_comb begin
    logic [63:0] wide;
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_nxt[0].n    = ps_r[PS_STEPS].s;
    sq_nxt[0].res  = '0;
    sq_nxt[0].zero = ps_r[PS_STEPS].zero;
    sq_nxt[0].neg  = ps_r[PS_STEPS].neg;
    for (int i = 0; i < 3; i++) begin
      wide           = 64'(ps_r[PS_STEPS].mag[i]) << ps_r[PS_STEPS].h;
      sq_nxt[0].x[i] = wide[31:0];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv  = 64'd1 << (62 - 2 * k);
      trial = sq_r[k].res + bitv;
      sq_nxt[k+1] = sq_r[k];
      if (sq_r[k].n >= trial) begin
        sq_nxt[k+1].n   = sq_r[k].n - trial;
        sq_nxt[k+1].res = (sq_r[k].res >> 1) + bitv;
      end else begin
        sq_nxt[k+1].res = sq_r[k].res >> 1;
      end
    end
  end

  // Rounded divide x * 2^30 / q, one quotient bit per stage.
  always_comb begin
    logic [62:0] num;
    logic [32:0] tr;
    logic [31:0] q;
    q              = sq_r[SQ_STEPS].res[31:0];
    dv_nxt[0].q    = q;
    dv_nxt[0].zero = sq_r[SQ_STEPS].zero;
    dv_nxt[0].neg  = sq_r[SQ_STEPS].neg;
    for (int i = 0; i < 3; i++) begin
      num = (63'(sq_r[SQ_STEPS].x[i]) << 30) + 63'(q >> 1);
      dv_nxt[0].rem[i] = {1'b0, num[62:31]};
      dv_nxt[0].low[i] = num[30:0];
      dv_nxt[0].quo[i] = '0;
    end
    for (int j = 0; j < DV_STEPS; j++) begin
      dv_nxt[j+1] = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        tr = {dv_r[j].rem[i][31:0], dv_r[j].low[i][30]};
        dv_nxt[j+1].low[i] = dv_r[j].low[i] << 1;
        if (tr >= {1'b0, dv_r[j].q}) begin
          dv_nxt[j+1].rem[i] = tr - {1'b0, dv_r[j].q};
          dv_nxt[j+1].quo[i] = {dv_r[j].quo[i][29:0], 1'b1};
        end else begin
          dv_nxt[j+1].rem[i] = tr;
          dv_nxt[j+1].quo[i] = {dv_r[j].quo[i][29:0], 1'b0};
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_r[DV_STEPS].zero) begin
        u_nxt[i] = '0;
      end else if (dv_r[DV_STEPS].neg[i]) begin
        u_nxt[i] = -$signed({1'b0, dv_r[DV_STEPS].quo[i]});
      end else begin
        u_nxt[i] = $signed({1'b0, dv_r[DV_STEPS].quo[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r <= mag_a_nxt;
      neg_a_r <= neg_a_nxt;
      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
      for (int i = 0; i < 3; i++) begin
        sq_b_r[i] <= mag_a_r[i] * mag_a_r[i];
      end
      for (int j = 0; j <= PS_STEPS; j++) begin
        ps_r[j] <= ps_nxt[j];
      end
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      for (int j = 0; j <= DV_STEPS; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
      u_r    <= u_nxt;
      zero_r <= dv_r[DV_STEPS].zero;
    end
  end

  assign u_o    = u_r;
  assign zero_o = zero_r;

endmodule

/* design/orbm_emit.sv */
// ---------------------------------------------------------------------------
// orbm_emit: vertex emitter
// Walks the 36 corner vertices of one box, one per cycle, and forms each
// saturated vertex position and its face normal in two register stages.
// ---------------------------------------------------------------------------
module orbm_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  orbm_pkg::rod_t      rod_i,
  output logic                free_o,
  output logic                out_valid_o,
  output orbm_pkg::out_item_t out_item_o
);

  // Corner code per vertex: bit 2 main axis sign, bit 1 first, bit 0 second.
  localparam logic [2:0] CORNER [36] = '{
    3'd7, 3'd5, 3'd4, 3'd7, 3'd4, 3'd6,
    3'd3, 3'd2, 3'd0, 3'd3, 3'd0, 3'd1,
    3'd7, 3'd6, 3'd2, 3'd7, 3'd2, 3'd3,
    3'd5, 3'd1, 3'd0, 3'd5, 3'd0, 3'd4,
    3'd7, 3'd3, 3'd1, 3'd7, 3'd1, 3'd5,
    3'd6, 3'd4, 3'd0, 3'd6, 3'd0, 3'd2
  };
  // Face per vertex: bits 2:1 normal axis, bit 0 set for the negative face.
  localparam logic [2:0] FACE [36] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef struct packed {
    logic [9:0]          slot;
    logic [5:0]          vnum;
    logic                last;
    logic                degen;
    logic [2:0][34:0]    a;
    logic [2:0][32:0]    b;
    orbm_pkg::nvec_t     nrm;
  } e1_t;

  orbm_pkg::rod_t      rod_r;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                act_r, act_nxt;
  logic                e1_v_r;
  e1_t                 e1_r, e1_nxt;
  logic                out_valid_r;
  orbm_pkg::out_item_t out_r, out_nxt;

  assign free_o = !act_r || (cnt_r == orbm_pkg::VERT_LAST);

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (load_i) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (act_r) begin
      if (cnt_r == orbm_pkg::VERT_LAST) begin
        act_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  // First stage: signed half-sums of the corner.
  always_comb begin
    logic [2:0]      code;
    logic [2:0]      face;
    orbm_pkg::nvec_t nsel;
    code = CORNER[cnt_r];
    face = FACE[cnt_r];
    case (face[2:1])
      2'd0:    nsel = rod_r.nrm[0];
      2'd1:    nsel = rod_r.nrm[1];
      default: nsel = rod_r.nrm[2];
    endcase
    e1_nxt.slot  = rod_r.slot;
    e1_nxt.vnum  = cnt_r;
    e1_nxt.last  = (cnt_r == orbm_pkg::VERT_LAST);
    e1_nxt.degen = rod_r.degen;
    for (int i = 0; i < 3; i++) begin
      e1_nxt.a[i] = 35'($signed(rod_r.cen[i])) +
                    (code[2] ? 35'($signed(rod_r.m[i])) : -35'($signed(rod_r.m[i])));
      e1_nxt.b[i] = (code[1] ? 33'($signed(rod_r.f[i])) : -33'($signed(rod_r.f[i]))) +
                    (code[0] ? 33'($signed(rod_r.s[i])) : -33'($signed(rod_r.s[i])));
      e1_nxt.nrm[i] = face[0] ? -$signed(nsel[i]) : $signed(nsel[i]);
    end
  end

  // Second stage: full sum and saturation to the signed 32-bit range.
  always_comb begin
    logic signed [35:0] p;
    logic [2:0][31:0]   v;
    for (int i = 0; i < 3; i++) begin
      p = 36'($signed(e1_r.a[i])) + 36'($signed(e1_r.b[i]));
      if (p[35:31] == 5'b00000 || p[35:31] == 5'b11111) begin
        v[i] = p[31:0];
      end else if (p[35]) begin
        v[i] = 32'h8000_0000;
      end else begin
        v[i] = 32'h7FFF_FFFF;
      end
    end
    out_nxt.slot_out      = e1_r.slot;
    out_nxt.vertex_number = e1_r.vnum;
    out_nxt.vert_x        = v[0];
    out_nxt.vert_y        = v[1];
    out_nxt.vert_z        = v[2];
    out_nxt.norm_x        = e1_r.nrm[0];
    out_nxt.norm_y        = e1_r.nrm[1];
    out_nxt.norm_z        = e1_r.nrm[2];
    out_nxt.degenerate    = e1_r.degen;
    out_nxt.last_vertex   = e1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      cnt_r       <= '0;
      e1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      cnt_r       <= cnt_nxt;
      e1_v_r      <= act_r;
      out_valid_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      rod_r <= rod_i;
    end
    e1_r  <= e1_nxt;
    out_r <= out_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_item_o  = out_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for oriented_rod_box_mesher
// Sends rods through the command port, predicts all 36 vertices of each rod
// in fixed point and checks every vertex result against that prediction.
// ---------------------------------------------------------------------------
module testbench;

  localparam int SLOTS      = 1024;
  localparam int WATCHDOG   = 20000;
  localparam int DRAIN_WAIT = 200;

  // Corner code: bit 2 is the sign of the main axis, bit 1 of the first
  // side axis and bit 0 of the second side axis (1 means plus).
  localparam logic [2:0] FACE_CORNER [6][4] = '{
    '{3'd7, 3'd5, 3'd4, 3'd6}, '{3'd3, 3'd2, 3'd0, 3'd1}, '{3'd7, 3'd6, 3'd2, 3'd3},
    '{3'd5, 3'd1, 3'd0, 3'd4}, '{3'd7, 3'd3, 3'd1, 3'd5}, '{3'd6, 3'd4, 3'd0, 3'd2}};
  localparam int TRI_CORNER [2][3] = '{'{0, 1, 2}, '{0, 2, 3}};

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  orbm_pkg::in_item_t  in_item;
  logic                out_valid;
  orbm_pkg::out_item_t out_item;

  orbm_pkg::in_item_t  pending_rods[$];
  orbm_pkg::out_item_t expected_vertices[$];
  int        error_count;
  int        rods_sent;
  int        vertices_checked;
  int        degenerate_seen;
  int        idle_cycles;
  bit        quiet_tail;
  bit        hold_sender;
  int        send_gap;

  oriented_rod_box_mesher #(.ROD_SLOTS(SLOTS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Rounds num/den to nearest with ties away from zero.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // Unit vector in Q2.30. Returns 0 when the input vector has zero length.
  function automatic bit to_unit(input longint c[3], output longint u[3]);
    longint unsigned sq;
    longint unsigned root;
    int              shift;
    longint          scale;
    sq    = 0;
    shift = 0;
    for (int i = 0; i < 3; i++) sq += longint'(c[i] * c[i]);
    if (sq == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    while (sq < (64'd1 << 60)) begin
      sq    = sq << 2;
      shift = shift + 2;
    end
    root  = int_sqrt(sq);
    scale = longint'(1) << (shift / 2);
    for (int i = 0; i < 3; i++) u[i] = round_div(c[i] * scale * (longint'(1) << 30), root);
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Appends the 36 vertices that one rod produces to the expected queue.
  task automatic mesh_rod(input orbm_pkg::in_item_t rod);
    longint    cen[3], d[3], c1[3], c2[3], um[3], uf[3], us[3];
    longint    axis[3][3], nrm[3][3];
    longint    len_sum, p, sgn;
    bit        dir_ok, degen;
    logic [2:0] code;
    orbm_pkg::out_item_t v;
    int        n;
    if (rod.rod_slot >= SLOTS) return;
    cen[0] = rod.center_x; cen[1] = rod.center_y; cen[2] = rod.center_z;
    d[0]   = rod.dir_x;    d[1]   = rod.dir_y;    d[2]   = rod.dir_z;
    if (d[0] != 0 || d[1] != 0) begin
      c1[0] = d[1]; c1[1] = -d[0]; c1[2] = 0;
    end else begin
      c1[0] = 0; c1[1] = d[2]; c1[2] = 0;
    end
    c2[0] = d[1] * c1[2] - d[2] * c1[1];
    c2[1] = d[2] * c1[0] - d[0] * c1[2];
    c2[2] = d[0] * c1[1] - d[1] * c1[0];
    dir_ok = to_unit(d, um);
    void'(to_unit(c1, uf));
    void'(to_unit(c2, us));
    degen   = !dir_ok || rod.rod_diameter == 0;
    len_sum = longint'(rod.rod_length) + longint'(rod.rod_diameter);
    for (int i = 0; i < 3; i++) begin
      axis[0][i] = round_div(d[i] * len_sum, 64'd1 << 15);
      axis[1][i] = round_div(uf[i] * longint'(rod.rod_diameter), 64'd1 << 31);
      axis[2][i] = round_div(us[i] * longint'(rod.rod_diameter), 64'd1 << 31);
      nrm[0][i]  = degen ? 0 : round_div(um[i], 64'd1 << 16);
      nrm[1][i]  = degen ? 0 : round_div(uf[i], 64'd1 << 16);
      nrm[2][i]  = degen ? 0 : round_div(us[i], 64'd1 << 16);
    end
    n = 0;
    for (int f = 0; f < 6; f++) begin
      sgn = (f % 2 == 0) ? 1 : -1;
      for (int t = 0; t < 2; t++) begin
        for (int c = 0; c < 3; c++) begin
          code = FACE_CORNER[f][TRI_CORNER[t][c]];
          for (int i = 0; i < 3; i++) begin
            p = cen[i];
            p += code[2] ? axis[0][i] : -axis[0][i];
            p += code[1] ? axis[1][i] : -axis[1][i];
            p += code[0] ? axis[2][i] : -axis[2][i];
            case (i)
              0: begin
                v.vert_x = clamp32(p);
                v.norm_x = 16'(nrm[f / 2][i] * sgn);
              end
              1: begin
                v.vert_y = clamp32(p);
                v.norm_y = 16'(nrm[f / 2][i] * sgn);
              end
              default: begin
                v.vert_z = clamp32(p);
                v.norm_z = 16'(nrm[f / 2][i] * sgn);
              end
            endcase
          end
          v.slot_out      = rod.rod_slot;
          v.vertex_number = 6'(n);
          v.degenerate    = degen;
          v.last_vertex   = (6'(n) == orbm_pkg::VERT_LAST);
          expected_vertices.push_back(v);
          n++;
        end
      end
    end
  endtask

  function automatic orbm_pkg::in_item_t make_rod(longint cx, longint cy, longint cz, int dx,
                                                  int dy, int dz, longint len, longint dia,
                                                  int slot);
    orbm_pkg::in_item_t r;
    r.center_x     = 32'(cx);
    r.center_y     = 32'(cy);
    r.center_z     = 32'(cz);
    r.dir_x        = 16'(dx);
    r.dir_y        = 16'(dy);
    r.dir_z        = 16'(dz);
    r.rod_length   = 31'(len);
    r.rod_diameter = 31'(dia);
    r.rod_slot     = 10'(slot);
    return r;
  endfunction

  // A random direction component: mostly within one in Q1.14, sometimes zero or raw.
  function automatic int rand_dir_component();
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 65535)) - 32768;
      1:       return 0;
      2:       return ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic longint rand_span();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 32'h7FFFFFFF);
      1:       return 0;
      default: return $urandom_range(0, 32'h00FFFFFF);
    endcase
  endfunction

  initial begin
    orbm_pkg::in_item_t r;
    // Directed rods: axis directions, zero and non-unit directions, zero diameter,
    // the extremes of every field and positions that saturate.
    pending_rods.push_back(make_rod(0, 0, 0, 16384, 0, 0, 32'h20000, 32'h10000, 0));
    pending_rods.push_back(make_rod(0, 0, 0, 0, 16384, 0, 32'h20000, 32'h10000, 1));
    pending_rods.push_back(make_rod(0, 0, 0, 0, 0, 16384, 32'h20000, 32'h10000, 2));
    pending_rods.push_back(make_rod(0, 0, 0, 0, 0, -16384, 32'h20000, 32'h10000, 3));
    pending_rods.push_back(make_rod(5, 6, 7, 0, 0, 0, 32'h20000, 32'h10000, 4));
    pending_rods.push_back(make_rod(0, 0, 0, 11585, 11585, 0, 32'h30000, 0, 5));
    pending_rods.push_back(make_rod(100, -100, 50, 9459, 9459, 9459, 32'h18000, 32'h8000, 6));
    pending_rods.push_back(make_rod(0, 0, 0, -32768, -32768, -32768, 32'h10000, 32'h10000, 7));
    pending_rods.push_back(make_rod(0, 0, 0, 32767, 1, -1, 32'h10000, 32'h10000, 8));
    pending_rods.push_back(make_rod(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16384, 16384,
                                    16384, 32'h7FFFFFFF, 32'h7FFFFFFF, 1023));
    pending_rods.push_back(make_rod(-2147483648, -2147483648, -2147483648, -16384, -16384,
                                    -16384, 32'h7FFFFFFF, 32'h7FFFFFFF, 512));
    pending_rods.push_back(make_rod(0, 0, 0, -16384, 0, 0, 0, 0, 9));
    pending_rods.push_back(make_rod(0, 0, 0, 3, -5, 2, 32'h40000, 32'h7FFFFFFF, 341));
    pending_rods.push_back(make_rod(-1, 1, -1, 0, 0, 1, 1, 1, 682));
    pending_rods.push_back(make_rod(0, 0, 0, 0, -16384, 0, 32'h55555555, 32'h2AAAAAAA, 10));
    for (int k = 0; k < 150; k++) begin
      r = make_rod($urandom(), $urandom(), $urandom(), rand_dir_component(),
                   rand_dir_component(), rand_dir_component(), rand_span(), rand_span(),
                   $urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 2) == 0) begin
        r.center_x = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
        r.center_y = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
        r.center_z = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
      end
      pending_rods.push_back(r);
    end
  end

  // Driver: one rod per transaction, random idle bursts, a single hold after 80 rods
  // until the mesher has drained, and no idling in the last stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      start       <= 1'b0;
      send_gap    <= 0;
      hold_sender <= 1'b0;
      quiet_tail  <= 1'b0;
    end else begin
      if (start && !busy) begin
        mesh_rod(in_item);
        rods_sent = rods_sent + 1;
      end
      if (start && busy) begin
        // The current transaction waits for the mesher.
      end else if (hold_sender) begin
        start <= 1'b0;
        if (expected_vertices.size() == 0 && !out_valid) hold_sender <= 1'b0;
      end else if (send_gap > 0) begin
        start    <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_rods.size() == 0) begin
        start <= 1'b0;
      end else if (rods_sent == 80 && start) begin
        // Let every expected vertex come back before sending more.
        start       <= 1'b0;
        hold_sender <= 1'b1;
      end else if (!quiet_tail && start && $urandom_range(0, 3) == 0) begin
        start    <= 1'b0;
        send_gap <= $urandom_range(0, 2);
      end else begin
        in_item <= pending_rods.pop_front();
        start   <= 1'b1;
      end
      if (pending_rods.size() < 20) quiet_tail <= 1'b1;
    end
  end

  // Monitor: each vertex is accepted in the cycle its strobe is high.
  always @(posedge clk) begin
    orbm_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex, actual %p", $time, out_item);
        error_count = error_count + 1;
      end else begin
        want = expected_vertices.pop_front();
        vertices_checked = vertices_checked + 1;
        if (out_item.degenerate) degenerate_seen = degenerate_seen + 1;
        if (out_item !== want) begin
          $display("%0t: vertex mismatch, expected %p, actual %p", $time, want, out_item);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Watchdog: counts cycles with no accepted transaction on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_item          = '0;
    error_count      = 0;
    rods_sent        = 0;
    vertices_checked = 0;
    degenerate_seen  = 0;
    idle_cycles      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      begin
        wait (pending_rods.size() == 0 && !start && expected_vertices.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG);
        $display("%0t: watchdog expired with %0d vertices outstanding", $time,
                 expected_vertices.size());
        $display("oriented_rod_box_mesher test failed");
        $finish;
      end
    join_any
    $display("Sent %0d rods and checked %0d vertices, %0d of them degenerate.", rods_sent,
             vertices_checked, degenerate_seen);
    if (error_count == 0 && expected_vertices.size() == 0) begin
      $display("oriented_rod_box_mesher test passed");
    end else begin
      $display("oriented_rod_box_mesher test failed");
    end
    $finish;
  end

endmodule

/* oriented_rod_box_mesher.f */
design/orbm_pkg.sv
design/orbm_norm.sv
design/orbm_emit.sv
design/oriented_rod_box_mesher.sv
tb/testbench.sv
